>>> src/sadd_pkg.sv
// Shared types, constants and the digit encoder of the switch accumulator display.
package sadd_pkg;

	localparam int unsigned SADD_QDEPTH = 4;

	localparam logic [26:0] COUNT_LIMIT = 27'd99999999;
	localparam logic [19:0] SHOW_LIMIT  = 20'd999999;

	// Division by ten as (v * DIV10_RECIP) >> DIV10_SHIFT, exact for v below 2**22.
	localparam logic [19:0] DIV10_RECIP = 20'd838861;
	localparam int unsigned DIV10_SHIFT = 23;

	localparam int unsigned KEY_ADD  = 0;
	localparam int unsigned KEY_CLR  = 1;
	localparam int unsigned KEY_HALT = 3;

	typedef struct packed {
		logic [26:0] count;
		logic        halted;
	} entry_t;

	typedef struct packed {
		logic [26:0]     count;
		logic            halted;
		logic            ovf;
		logic [19:0]     rest;
		logic [5:0][6:0] segs;
	} pipe_t;

	function automatic logic [6:0] seg_code(input logic [3:0] digit);
		logic [6:0] code;
		case (digit)
			4'd0: code = 7'h3F;
			4'd1: code = 7'h06;
			4'd2: code = 7'h5B;
			4'd3: code = 7'h4F;
			4'd4: code = 7'h66;
			4'd5: code = 7'h6D;
			4'd6: code = 7'h7D;
			4'd7: code = 7'h07;
			4'd8: code = 7'h7F;
			4'd9: code = 7'h6F;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

endpackage

>>> src/sadd_front.sv
// Front end: key edge detection, priority decode and the running count.
module sadd_front import sadd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [3:0] keys,
	input  logic [9:0] switches,
	input  logic       full,
	output logic       in_stall,
	output logic       push,
	output entry_t     push_data
);

	logic [3:0]  last_q;
	logic [26:0] count_q;
	logic        stopped_q;

	logic        accept;
	logic [3:0]  edges;
	logic [26:0] count_next;
	logic        halt_now;

	assign in_stall = full;
	assign accept   = in_valid & ~full;
	assign edges    = keys & ~last_q;

	always_comb begin
		count_next = count_q;
		halt_now   = 1'b0;
		if (edges[KEY_ADD]) begin
			if (count_q < COUNT_LIMIT) begin
				count_next = count_q + 27'(switches);
			end
		end else if (edges[KEY_CLR]) begin
			count_next = '0;
		end else if (edges[KEY_HALT]) begin
			count_next = '0;
			halt_now   = 1'b1;
		end
	end

	// Once halted, transactions are still taken but leave no trace.
	assign push             = accept & ~stopped_q & (edges != 4'd0);
	assign push_data.count  = count_next;
	assign push_data.halted = halt_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else if (accept && !stopped_q) begin
			last_q    <= keys;
			count_q   <= count_next;
			stopped_q <= halt_now;
		end
	end

endmodule

>>> src/sadd_queue.sv
// Short queue between the front end and the display pipeline.
module sadd_queue import sadd_pkg::*; #(
	parameter int unsigned DEPTH = SADD_QDEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	output logic   out_valid,
	output entry_t out_data,
	input  logic   out_stall
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid & ~out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> src/sadd_digit.sv
// One display pipeline stage: peels off the lowest decimal digit and encodes it.
module sadd_digit import sadd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  pipe_t in_data,
	output logic  in_stall,
	output logic  out_valid,
	output pipe_t out_data,
	input  logic  out_stall
);

	logic        valid_s1;
	pipe_t       data_s1;
	pipe_t       next;
	logic [39:0] prod;
	logic [16:0] quot;
	logic [19:0] rem;

	assign prod = 40'(in_data.rest) * 40'(DIV10_RECIP);
	assign quot = prod[DIV10_SHIFT +: 17];
	assign rem  = in_data.rest - 20'(quot) * 20'd10;

	always_comb begin
		next      = in_data;
		next.rest = 20'(quot);
		// The new code enters at the top; after six stages the units sit lowest.
		next.segs = {seg_code(rem[3:0]), in_data.segs[5:1]};
	end

	assign in_stall  = valid_s1 & out_stall;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= next;
		end
	end

endmodule

>>> src/sadd_back.sv
// Back end: saturation, overflow flag and the six-stage decimal display pipeline.
module sadd_back import sadd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  entry_t      q_data,
	output logic        q_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] seg_low,
	output logic [14:0] seg_high,
	output logic        overflow_led,
	output logic [26:0] count_value,
	output logic        halted
);

	pipe_t stg_data  [7];
	logic  stg_valid [7];
	logic  stg_stall [7];
	pipe_t last;

	always_comb begin
		stg_data[0].count  = q_data.count;
		stg_data[0].halted = q_data.halted;
		stg_data[0].ovf    = (q_data.count > COUNT_LIMIT);
		stg_data[0].rest   = (q_data.count > 27'(SHOW_LIMIT)) ? SHOW_LIMIT : q_data.count[19:0];
		stg_data[0].segs   = '0;
	end

	assign stg_valid[0] = q_valid;
	assign q_stall      = stg_stall[0];
	assign stg_stall[6] = out_stall;

	for (genvar i = 0; i < 6; i++) begin : g_digit
		sadd_digit u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_data   (stg_data[i]),
			.in_stall  (stg_stall[i]),
			.out_valid (stg_valid[i+1]),
			.out_data  (stg_data[i+1]),
			.out_stall (stg_stall[i+1])
		);
	end

	assign last      = stg_data[6];
	assign out_valid = stg_valid[6];

	// A halt transaction blanks the display entirely.
	assign seg_low = last.halted ? '0 :
		{last.segs[3], 1'b0, last.segs[2], 1'b0, last.segs[1], 1'b0, last.segs[0]};
	assign seg_high     = last.halted ? '0 : {last.segs[5], 1'b0, last.segs[4]};
	assign overflow_led = last.ovf;
	assign count_value  = last.count;
	assign halted       = last.halted;

endmodule

>>> src/switch_accumulator_decimal_display.sv
// Top level of the switch accumulator with six-digit seven-segment output.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-----------------------------------------
//   input    | in_valid / in_stall          | keys, switches
//   output   | out_valid / out_stall        | seg_low, seg_high, overflow_led,
//            |                              | count_value, halted
//
// One poll is accepted every cycle; in_stall rises only when the queue is full.
// A result passes through the queue and then the six digit stages of the display
// pipeline, one divide-by-ten multiplier each.
// Reset clears the key history, the count, the halt flag, the queue and all stage valids.
// A stall at the output backs up the digit stages, then the queue, then the input via in_stall.
module switch_accumulator_decimal_display import sadd_pkg::*; #(
	parameter int unsigned QDEPTH = SADD_QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  keys,
	input  logic [9:0]  switches,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] seg_low,
	output logic [14:0] seg_high,
	output logic        overflow_led,
	output logic [26:0] count_value,
	output logic        halted
);

	logic   push;
	entry_t push_data;
	logic   full;
	logic   q_valid;
	entry_t q_data;
	logic   q_stall;

	sadd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.keys      (keys),
		.switches  (switches),
		.full      (full),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data)
	);

	sadd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (q_valid),
		.out_data  (q_data),
		.out_stall (q_stall)
	);

	sadd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_stall      (q_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.seg_low      (seg_low),
		.seg_high     (seg_high),
		.overflow_led (overflow_led),
		.count_value  (count_value),
		.halted       (halted)
	);

endmodule

>>> src/sadd_checker.sv
// Port-level checks of the switch accumulator display, bound to the top level.
module sadd_checker import sadd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [3:0]  keys,
	input logic [9:0]  switches,
	input logic        out_valid,
	input logic        out_stall,
	input logic [30:0] seg_low,
	input logic [14:0] seg_high,
	input logic        overflow_led,
	input logic [26:0] count_value,
	input logic        halted
);

	localparam logic [30:0] NINES_LOW  = 31'h6F6F6F6F;
	localparam logic [14:0] NINES_HIGH = 15'h6F6F;

	// A stalled output transaction holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(seg_low) && $stable(seg_high)
			&& $stable(overflow_led) && $stable(count_value) && $stable(halted))
		else $error("output transaction changed while stalled");

	a_halt_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halted |-> seg_low == '0 && seg_high == '0 && count_value == '0
			&& !overflow_led)
		else $error("halt result is not blank");

	a_ovf_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> overflow_led == (count_value > COUNT_LIMIT))
		else $error("overflow flag disagrees with count");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_value > 27'(SHOW_LIMIT) |-> seg_low == NINES_LOW
			&& seg_high == NINES_HIGH)
		else $error("large count not shown as all nines");

endmodule

bind switch_accumulator_decimal_display sadd_checker u_sadd_checker (.*);
